// ----- hw/rtl/tile_cone_range_query_core_macros.svh -----
// Assertion macros used by the checker file tcrq_checker.sv.
`ifndef TILE_CONE_RANGE_QUERY_CORE_MACROS_SVH
`define TILE_CONE_RANGE_QUERY_CORE_MACROS_SVH

// Same-cycle implication.
`define TCRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcrq: same-cycle check failed");

// Next-cycle implication.
`define TCRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcrq: next-cycle check failed");

`endif

// ----- hw/rtl/tcrq_pkg.sv -----
package tcrq_pkg;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam int ATAB_LEN = 24;
	localparam int ITER_W = 5;
	localparam int XY_W = 34;
	localparam int Z_W = 26;

	localparam logic signed [Z_W-1:0] Z_QUARTER = 26'sd4194304;
	localparam logic signed [Z_W-1:0] Z_HALF = 26'sd8388608;
	localparam logic [16:0] GAIN_Q16 = 17'd107922;

	localparam logic [21:0] ATAN_TAB [ATAB_LEN] = '{
		22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
		22'd41718, 22'd20860, 22'd10430, 22'd5215, 22'd2608, 22'd1304,
		22'd652, 22'd326, 22'd163, 22'd81, 22'd41, 22'd20,
		22'd10, 22'd5, 22'd3, 22'd1, 22'd1, 22'd0
	};

	typedef struct packed {
		logic func;
		logic [4:0] index;
		logic signed [19:0] pos_x;
		logic signed [19:0] pos_y;
		logic [15:0] heading;
		logic flag_intersection;
		logic flag_merge;
		logic [18:0] radius;
		logic [15:0] max_angle;
		logic [18:0] max_lateral;
		logic lateral_enable;
	} item_t;

	typedef struct packed {
		logic match;
		logic [4:0] tile_index;
		logic signed [19:0] tile_x;
		logic signed [19:0] tile_y;
		logic [15:0] tile_heading;
		logic tile_is_intersection;
		logic tile_is_merge;
		logic last;
	} result_t;

	typedef struct packed {
		logic wr_tile;
		logic ld_query;
		logic rd_tile;
		logic ld_tile;
		logic ld_sq;
		logic ld_rot;
		logic step;
		logic ld_vec;
		logic emit_tile;
		logic emit_end;
		logic [ITER_W-1:0] iter;
	} cmd_t;

	typedef struct packed {
		logic tile_ok;
		logic lat_ok;
		logic ang_ok;
	} status_t;

	function automatic logic signed [Z_W-1:0] atan_at(input logic [ITER_W-1:0] i);
		logic signed [Z_W-1:0] r;
		r = '0;
		if (i < ITER_W'(ATAB_LEN)) begin
			r = $signed({4'b0000, ATAN_TAB[i]});
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/tcrq_ram.sv -----
module tcrq_ram #(
	parameter int WIDTH = 58,
	parameter int DEPTH = 32,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic clk,
	input  logic we,
	input  logic [AW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/tcrq_ctrl.sv -----
module tcrq_ctrl
	import tcrq_pkg::*;
#(
	parameter int MAX_TILES = 32,
	parameter int CORDIC_STEPS = 16,
	parameter int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1,
	parameter int CW = $clog2(MAX_TILES + 1)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  item_t item,
	input  logic cfg_valid,
	input  logic [5:0] cfg_data,
	input  status_t status,
	output cmd_t cmd,
	output logic [AW-1:0] tile_addr,
	output logic busy
);

	localparam int STEPS = (CORDIC_STEPS < ATAB_LEN) ? CORDIC_STEPS : ATAB_LEN;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_LD, S_SQ, S_CHK, S_ROT, S_LAT, S_VEC, S_ANG, S_END
	} state_t;

	state_t state_q;
	logic [AW-1:0] t_q;
	logic [ITER_W-1:0] iter_q;
	logic [CW-1:0] n_q;
	logic [5:0] count_q;
	logic [CW-1:0] n_sat;
	logic [CW-1:0] t_next;
	logic last_tile;
	logic last_iter;
	logic idle_start;
	logic [6:0] idx7;

	assign n_sat = ({1'b0, count_q} > 7'(MAX_TILES)) ? CW'(MAX_TILES) : CW'(count_q);
	assign t_next = CW'(t_q) + CW'(1);
	assign last_tile = (t_next == n_q);
	assign last_iter = (iter_q == ITER_W'(STEPS - 1));
	assign idle_start = (state_q == S_IDLE) && start;
	assign idx7 = {2'b00, item.index};
	assign busy = (state_q != S_IDLE);
	assign tile_addr = t_q;

	always_comb begin
		cmd = '0;
		cmd.wr_tile = idle_start && (item.func == FUNC_WRITE) && (idx7 < 7'(MAX_TILES));
		cmd.ld_query = idle_start && (item.func == FUNC_QUERY);
		cmd.rd_tile = (state_q == S_RD);
		cmd.ld_tile = (state_q == S_LD);
		cmd.ld_sq = (state_q == S_SQ);
		cmd.ld_rot = (state_q == S_CHK) && status.tile_ok;
		cmd.step = (state_q == S_ROT) || (state_q == S_VEC);
		cmd.ld_vec = (state_q == S_LAT) && status.lat_ok;
		cmd.emit_tile = (state_q == S_ANG) && status.ang_ok;
		cmd.emit_end = (state_q == S_END);
		cmd.iter = iter_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q <= '0;
			iter_q <= '0;
			n_q <= '0;
			count_q <= '0;
		end else begin
			if (cfg_valid) begin
				count_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start && item.func == FUNC_QUERY) begin
						n_q <= n_sat;
						t_q <= '0;
						state_q <= (n_sat == '0) ? S_END : S_RD;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: state_q <= S_SQ;
				S_SQ: state_q <= S_CHK;
				S_CHK, S_LAT, S_ANG: begin
					if ((state_q == S_CHK && status.tile_ok) ||
					    (state_q == S_LAT && status.lat_ok)) begin
						iter_q <= '0;
						state_q <= (state_q == S_CHK) ? S_ROT : S_VEC;
					end else if (last_tile) begin
						state_q <= S_END;
					end else begin
						t_q <= t_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_ROT, S_VEC: begin
					iter_q <= iter_q + ITER_W'(1);
					if (last_iter) begin
						state_q <= (state_q == S_ROT) ? S_LAT : S_ANG;
					end
				end
				S_END: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/tcrq_dp.sv -----
module tcrq_dp
	import tcrq_pkg::*;
#(
	parameter int MAX_TILES = 32,
	parameter int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1
) (
	input  logic clk,
	input  logic arst_n,
	input  item_t item,
	input  cmd_t cmd,
	input  logic [AW-1:0] tile_addr,
	output status_t status,
	output logic result_valid,
	output result_t result
);

	localparam int WORD_W = 58;

	logic [WORD_W-1:0] rdata;
	logic [5:0] idx6;
	logic [5:0] t6;

	logic signed [19:0] px_q, py_q;
	logic fi_q, fm_q, lat_en_q;
	logic [37:0] r2_q;
	logic [35:0] lat_lim_q;
	logic signed [Z_W-1:0] rot_q;
	logic [15:0] maxang_q;
	logic [15:0] nh;

	logic signed [19:0] tx_q, ty_q;
	logic [15:0] th_q;
	logic ti_q, tm_q, wanted_q;
	logic signed [20:0] dx_q, dy_q;
	logic [41:0] sqx_q, sqy_q;
	logic [42:0] dist2;

	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic vec_mode_q;
	logic signed [XY_W-1:0] u0, v0, xs, ys, w;
	logic signed [Z_W-1:0] atan;
	logic ccw;

	assign idx6 = {1'b0, item.index};
	assign t6 = 6'(tile_addr);

	tcrq_ram #(.WIDTH(WORD_W), .DEPTH(MAX_TILES), .AW(AW)) u_ram (
		.clk(clk),
		.we(cmd.wr_tile),
		.waddr(idx6[AW-1:0]),
		.wdata({item.pos_x, item.pos_y, item.heading, item.flag_merge,
			item.flag_intersection}),
		.re(cmd.rd_tile),
		.raddr(tile_addr),
		.rdata(rdata)
	);

	assign nh = 16'd0 - item.heading;
	assign dist2 = {1'b0, sqx_q} + {1'b0, sqy_q};
	assign u0 = {{5{dx_q[20]}}, dx_q, 8'h00};
	assign v0 = {{5{dy_q[20]}}, dy_q, 8'h00};
	assign xs = x_q >>> cmd.iter;
	assign ys = y_q >>> cmd.iter;
	assign atan = atan_at(cmd.iter);
	assign ccw = vec_mode_q ? !(y_q > 0) : (z_q >= 0);
	assign w = y_q[XY_W-1] ? -y_q : y_q;

	assign status.tile_ok = wanted_q && (dx_q != '0 || dy_q != '0) && (dist2 < {5'b0, r2_q});
	assign status.lat_ok = !lat_en_q || ({w, 8'h00} <= {6'b0, lat_lim_q});
	assign status.ang_ok = z_q < $signed({2'b00, maxang_q, 8'h00});

	always_ff @(posedge clk) begin
		if (cmd.ld_query) begin
			px_q <= item.pos_x;
			py_q <= item.pos_y;
			fi_q <= item.flag_intersection;
			fm_q <= item.flag_merge;
			lat_en_q <= item.lateral_enable;
			r2_q <= 38'(item.radius) * 38'(item.radius);
			lat_lim_q <= 36'(item.max_lateral) * 36'(GAIN_Q16);
			rot_q <= {{2{nh[15]}}, nh, 8'h00};
			maxang_q <= item.max_angle;
		end
		if (cmd.ld_tile) begin
			tx_q <= rdata[57:38];
			ty_q <= rdata[37:18];
			th_q <= rdata[17:2];
			tm_q <= rdata[1];
			ti_q <= rdata[0];
			wanted_q <= (fi_q && rdata[0]) || (fm_q && rdata[1]);
			dx_q <= {rdata[57], rdata[57:38]} - {px_q[19], px_q};
			dy_q <= {rdata[37], rdata[37:18]} - {py_q[19], py_q};
		end
		if (cmd.ld_sq) begin
			sqx_q <= 42'(42'(dx_q) * 42'(dx_q));
			sqy_q <= 42'(42'(dy_q) * 42'(dy_q));
		end
		if (cmd.ld_rot) begin
			vec_mode_q <= 1'b0;
			// Angles beyond a quarter turn start from the opposite half plane.
			if (rot_q > Z_QUARTER) begin
				x_q <= -u0;
				y_q <= -v0;
				z_q <= rot_q - Z_HALF;
			end else if (rot_q < -Z_QUARTER) begin
				x_q <= -u0;
				y_q <= -v0;
				z_q <= rot_q + Z_HALF;
			end else begin
				x_q <= u0;
				y_q <= v0;
				z_q <= rot_q;
			end
		end else if (cmd.ld_vec) begin
			vec_mode_q <= 1'b1;
			if (x_q[XY_W-1]) begin
				x_q <= w;
				y_q <= -x_q;
				z_q <= Z_QUARTER;
			end else begin
				y_q <= w;
				z_q <= '0;
			end
		end else if (cmd.step) begin
			if (ccw) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan;
			end
		end
		if (cmd.emit_tile) begin
			result <= {1'b1, t6[4:0], tx_q, ty_q, th_q, ti_q, tm_q, 1'b0};
		end else if (cmd.emit_end) begin
			result <= '{last: 1'b1, default: '0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit_tile || cmd.emit_end;
		end
	end

endmodule

// ----- hw/rtl/tile_cone_range_query_core.sv -----
// Tile table with a range and cone query.
// Input: an item is taken when start is high and busy is low. A write item
// stores one tile and leaves busy low. A query item raises
// busy and walks slots 0 to tile_count-1 (saturated to MAX_TILES).
// Configuration: cfg_valid/cfg_data write tile_count; cfg_ready is always high.
// Per slot the walk reads the table, forms the offset, squares it and runs the
// range test; a tile that passes the range test is rotated and checked against
// the lateral limit and, if it passes the lateral test, vectored and checked
// against the angle limit. One shared CORDIC unit does both.
// Output: each result, and the final end marker with last set, is shown for one
// cycle with result_valid high. The receiver cannot stall; the end marker is
// shown in the first cycle that busy is low again.
// Reset clears the controller and tile_count; the table contents stay
// undefined until written.
module tile_cone_range_query_core
	import tcrq_pkg::*;
#(
	parameter int MAX_TILES = 32,
	parameter int CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  item_t item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [5:0] cfg_data,
	output logic result_valid,
	output result_t result
);

	localparam int AW = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;

	cmd_t cmd;
	status_t status;
	logic [AW-1:0] tile_addr;

	assign cfg_ready = 1'b1;

	tcrq_ctrl #(.MAX_TILES(MAX_TILES), .CORDIC_STEPS(CORDIC_STEPS), .AW(AW)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.cfg_valid(cfg_valid),
		.cfg_data(cfg_data),
		.status(status),
		.cmd(cmd),
		.tile_addr(tile_addr),
		.busy(busy)
	);

	tcrq_dp #(.MAX_TILES(MAX_TILES), .AW(AW)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cmd(cmd),
		.tile_addr(tile_addr),
		.status(status),
		.result_valid(result_valid),
		.result(result)
	);

endmodule

// ----- hw/rtl/tcrq_checker.sv -----
`include "tile_cone_range_query_core_macros.svh"

module tcrq_checker
	import tcrq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input item_t item,
	input logic result_valid,
	input result_t result
);

	// A query transaction keeps the block busy while it walks the table.
	`TCRQ_ASSERT_NXT(a_query_busy, clk, arst_n, start && !busy && item.func == FUNC_QUERY, busy)
	// A write transaction never raises busy.
	`TCRQ_ASSERT_NXT(a_write_idle, clk, arst_n, start && !busy && item.func == FUNC_WRITE, !busy)
	// The end marker carries no tile.
	`TCRQ_ASSERT_IMP(a_end_clear, clk, arst_n, result_valid && result.last,
		!result.match && result.tile_index == 5'd0)
	// A reported tile always comes with more results still owed.
	`TCRQ_ASSERT_IMP(a_tile_busy, clk, arst_n, result_valid && !result.last, busy && result.match)
	// Nothing follows the end marker at once.
	`TCRQ_ASSERT_NXT(a_end_quiet, clk, arst_n, result_valid && result.last, !result_valid)

endmodule

bind tile_cone_range_query_core tcrq_checker u_tcrq_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.item(item),
	.result_valid(result_valid),
	.result(result)
);

// ----- tb/tile_cone_range_query_checker.sv -----
module tile_cone_range_query_checker
	import tcrq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  item_t item,
	input  logic cfg_valid,
	input  logic cfg_ready,
	input  logic [5:0] cfg_data,
	input  logic result_valid,
	input  result_t result,
	output int fail_count,
	output int pending
);

	localparam int TILE_SLOTS = 32;
	localparam int SPIN_STEPS = 16;
	localparam longint LAT_GAIN = 107922;
	localparam longint ARC [SPIN_STEPS] = '{
		2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
		10430, 5215, 2608, 1304, 652, 326, 163, 81
	};

	logic signed [19:0] slot_x [TILE_SLOTS];
	logic signed [19:0] slot_y [TILE_SLOTS];
	logic [15:0] slot_heading [TILE_SLOTS];
	logic [1:0] slot_flags [TILE_SLOTS];
	logic [5:0] walk_count;
	result_t hits_q [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic report(input string what);
		$display("error at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Rotation by z in units of 2^24 per turn; >>> on longint rounds toward minus infinity.
	function automatic void spin(inout longint x, inout longint y, input longint z);
		longint xs, ys;
		if (z > 4194304) begin
			x = -x; y = -y; z -= 8388608;
		end else if (z < -4194304) begin
			x = -x; y = -y; z += 8388608;
		end
		for (int i = 0; i < SPIN_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z -= ARC[i];
			end else begin
				x = x + ys; y = y - xs; z += ARC[i];
			end
		end
	endfunction

	function automatic longint bearing(input longint u, input longint w);
		longint x, y, z, xs, ys;
		x = u; y = w; z = 0;
		if (u < 0) begin
			x = w; y = -u; z = 4194304;
		end
		for (int i = 0; i < SPIN_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z += ARC[i];
			end else begin
				x = x - ys; y = y + xs; z -= ARC[i];
			end
		end
		return z;
	endfunction

	task automatic predict_query(input item_t q);
		int n;
		longint dx, dy, u, v, w, rot, rad;
		logic [15:0] neg_hd;
		result_t r;
		n = (walk_count > TILE_SLOTS) ? TILE_SLOTS : walk_count;
		neg_hd = 16'd0 - q.heading;
		rot = longint'($signed(neg_hd)) * 256;
		rad = q.radius;
		for (int t = 0; t < n; t++) begin
			if (!((q.flag_intersection && slot_flags[t][0]) ||
					(q.flag_merge && slot_flags[t][1])))
				continue;
			dx = longint'(slot_x[t]) - longint'(q.pos_x);
			dy = longint'(slot_y[t]) - longint'(q.pos_y);
			if (dx == 0 && dy == 0)
				continue;
			if (dx * dx + dy * dy >= rad * rad)
				continue;
			u = dx * 256;
			v = dy * 256;
			spin(u, v, rot);
			w = (v < 0) ? -v : v;
			if (q.lateral_enable && w * 65536 > longint'(q.max_lateral) * 256 * LAT_GAIN)
				continue;
			if (bearing(u, w) >= longint'(q.max_angle) * 256)
				continue;
			r = '0;
			r.match = 1'b1;
			r.tile_index = t[4:0];
			r.tile_x = slot_x[t];
			r.tile_y = slot_y[t];
			r.tile_heading = slot_heading[t];
			r.tile_is_intersection = slot_flags[t][0];
			r.tile_is_merge = slot_flags[t][1];
			hits_q = {hits_q, r};
		end
		r = '0;
		r.last = 1'b1;
		hits_q = {hits_q, r};
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_count = '0;
			hits_q.delete();
		end else begin
			if (result_valid) begin
				result_t e;
				if (hits_q.size() == 0) begin
					report("result with no expectation waiting");
				end else begin
					e = hits_q.pop_front();
					if (result.match !== e.match) report("match differs");
					if (result.tile_index !== e.tile_index) report("tile_index differs");
					if (result.tile_x !== e.tile_x) report("tile_x differs");
					if (result.tile_y !== e.tile_y) report("tile_y differs");
					if (result.tile_heading !== e.tile_heading) report("tile_heading differs");
					if (result.tile_is_intersection !== e.tile_is_intersection)
						report("tile_is_intersection differs");
					if (result.tile_is_merge !== e.tile_is_merge) report("tile_is_merge differs");
					if (result.last !== e.last) report("last differs");
				end
			end
			if (cfg_valid && cfg_ready)
				walk_count = cfg_data;
			if (start && !busy) begin
				if (item.func == FUNC_WRITE) begin
					slot_x[item.index] = item.pos_x;
					slot_y[item.index] = item.pos_y;
					slot_heading[item.index] = item.heading;
					slot_flags[item.index] = {item.flag_merge, item.flag_intersection};
				end else begin
					predict_query(item);
				end
			end
		end
		pending = hits_q.size();
	end

endmodule

// ----- tb/tile_cone_range_query_core_test.sv -----
module tile_cone_range_query_core_test;
	import tcrq_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	item_t item = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [5:0] cfg_data = '0;
	logic result_valid;
	result_t result;
	int fail_count;
	int pending;
	int cycles = 0;
	int idle_pct = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tile_cone_range_query_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .result(result)
	);

	tile_cone_range_query_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.result_valid(result_valid), .result(result),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_item(input item_t it);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		item = it;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
	endtask

	// Let outstanding results drain, then give the block time to go idle.
	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_count(input logic [5:0] n);
		drain();
		cfg_valid = 1'b1;
		cfg_data = n;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic signed [19:0] near_coord();
		if ($urandom_range(9) < 8)
			return 20'($signed($urandom_range(8000)) - 4000);
		return 20'($urandom);
	endfunction

	function automatic item_t tile_item(input logic [4:0] idx, input logic signed [19:0] x,
			input logic signed [19:0] y, input logic [15:0] hd, input logic [1:0] fl);
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom});
		it.func = FUNC_WRITE;
		it.index = idx;
		it.pos_x = x;
		it.pos_y = y;
		it.heading = hd;
		{it.flag_merge, it.flag_intersection} = fl;
		return it;
	endfunction

	function automatic item_t query_item(input logic signed [19:0] x, input logic signed [19:0] y,
			input logic [15:0] hd, input logic [18:0] rad, input logic [15:0] ang,
			input logic [18:0] lat, input logic lat_en, input logic [1:0] fl);
		item_t it;
		it = item_t'({$urandom, $urandom, $urandom, $urandom});
		it.func = FUNC_QUERY;
		it.pos_x = x;
		it.pos_y = y;
		it.heading = hd;
		it.radius = rad;
		it.max_angle = ang;
		it.max_lateral = lat;
		it.lateral_enable = lat_en;
		{it.flag_merge, it.flag_intersection} = fl;
		return it;
	endfunction

	function automatic item_t random_query();
		logic [18:0] rad, lat;
		rad = ($urandom_range(9) < 8) ? 19'($urandom_range(6000)) : 19'($urandom);
		lat = ($urandom_range(3) < 3) ? 19'($urandom_range(4000)) : 19'($urandom);
		return query_item(near_coord(), near_coord(), 16'($urandom), rad,
			16'($urandom_range(32768)), lat, 1'($urandom), 2'($urandom));
	endfunction

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: an empty walk, then six hand-placed tiles and queries over them.
		set_count(6'd0);
		push_item(query_item(0, 0, 0, 19'd524287, 16'd32768, 0, 0, 2'b11));
		push_item(tile_item(0, -20'sd524288, 20'sd524287, 16'hFFFF, 2'b11));
		push_item(tile_item(1, 0, 0, 0, 2'b11));
		push_item(tile_item(2, 20'sd1000, 0, 16'd100, 2'b01));
		push_item(tile_item(3, 0, 20'sd1000, 16'd16384, 2'b10));
		push_item(tile_item(4, -20'sd1000, 0, 16'd32768, 2'b11));
		push_item(tile_item(5, 20'sd700, -20'sd700, 16'd49152, 2'b00));
		set_count(6'd6);
		push_item(query_item(0, 0, 0, 19'd2000, 16'd32768, 0, 0, 2'b11));
		push_item(query_item(0, 0, 0, 19'd2000, 16'd32768, 0, 1, 2'b11));
		push_item(query_item(0, 0, 0, 19'd2000, 16'd32768, 19'd524287, 1, 2'b01));
		push_item(query_item(0, 0, 0, 19'd2000, 16'd0, 0, 0, 2'b11));
		push_item(query_item(0, 0, 0, 19'd0, 16'd32768, 0, 0, 2'b11));
		push_item(query_item(0, 0, 0, 19'd1000, 16'd32768, 0, 0, 2'b11));
		push_item(query_item(0, 0, 16'd16384, 19'd2000, 16'd8192, 0, 0, 2'b10));
		push_item(query_item(0, 0, 16'd49152, 19'd2000, 16'd16384, 19'd300, 1, 2'b11));
		push_item(query_item(0, 0, 16'd32768, 19'd2000, 16'd16385, 0, 0, 2'b11));
		push_item(query_item(20'sd524287, -20'sd524288, 16'hFFFF, 19'd524287, 16'd32768,
			19'd524287, 1, 2'b11));
		push_item(query_item(-20'sd524288, 20'sd524287, 0, 19'd524287, 16'd32767, 0, 0, 2'b11));
		set_count(6'd63);

		// Every slot gets written before any walk can reach it.
		idle_pct = 6;
		for (int s = 0; s < 32; s++)
			push_item(tile_item(5'(s), near_coord(), near_coord(), 16'($urandom), 2'($urandom)));

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 6 : (phase == 1) ? 64 : 0;
			case (phase)
				0: set_count(6'd32);
				1: set_count(6'($urandom_range(1, 31)));
				default: set_count(6'd63);
			endcase
			for (int k = 0; k < 103; k++) begin
				if (phase == 2 && k == 55)
					while (pending != 0) @(negedge clk);
				if ($urandom_range(9) < 3)
					push_item(tile_item(5'($urandom), near_coord(), near_coord(),
						16'($urandom), 2'($urandom)));
				else
					push_item(random_query());
			end
		end

		drain();
		repeat (100) @(negedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/tcrq_pkg.sv
hw/rtl/tcrq_ram.sv
hw/rtl/tcrq_ctrl.sv
hw/rtl/tcrq_dp.sv
hw/rtl/tile_cone_range_query_core.sv
hw/rtl/tcrq_checker.sv
tb/tile_cone_range_query_checker.sv
tb/tile_cone_range_query_core_test.sv
